// ----- design/assert_macros.svh -----
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/fpwc_pkg.sv -----
package fpwc_pkg;

    localparam int ADDR_W      = 17;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_FLUSH = 2'd1;
    localparam logic [1:0] FUNC_ERASE = 2'd2;

    localparam logic [1:0] CMD_LOAD        = 2'd0;
    localparam logic [1:0] CMD_ERASE_WRITE = 2'd1;
    localparam logic [1:0] CMD_ERASE       = 2'd2;

    typedef struct packed {
        logic [1:0]        func;
        logic [ADDR_W-1:0] byte_address;
        logic [7:0]        data_byte;
        logic [7:0]        page_number;
    } item_t;

    typedef struct packed {
        logic [1:0]        command;
        logic [ADDR_W-1:0] command_address;
        logic [15:0]       word_data;
        logic              last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

// ----- design/flash_page_write_combiner.sv -----
// Channel  Handshake            Payload
// in       in_valid / in_ready  func, byte_address, data_byte, page_number
// out      out_valid/ out_ready command, command_address, word_data, last
//
// One item a cycle: input register, one pass of decode and state update, result queue.
// An accepted item passes the input register, then its first result enters the queue.
// An item giving two commands fills two queue slots; the four-entry queue absorbs them.
// The input side stalls only when the queue lacks room for the staged item's commands.
// Reset clears held page, dirty flag, low byte latch, staged valid flag and the queue.
module flash_page_write_combiner
    import fpwc_pkg::*;
#(
    parameter int PAGE_BYTES   = 512,
    parameter int ADDRESS_BITS = 17
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        func,
    input  logic [ADDR_W-1:0] byte_address,
    input  logic [7:0]        data_byte,
    input  logic [7:0]        page_number,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        command,
    output logic [ADDR_W-1:0] command_address,
    output logic [15:0]       word_data,
    output logic              last
);

    item_t             in_item;
    item_t             stg_item;
    logic              stg_valid;
    logic              consume;
    logic [QCNT_W-1:0] free;
    push_t             push;
    result_t           result;

    assign in_item.func         = func;
    assign in_item.byte_address = byte_address;
    assign in_item.data_byte    = data_byte;
    assign in_item.page_number  = page_number;

    fpwc_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .consume   (consume),
        .stg_valid (stg_valid),
        .stg_item  (stg_item)
    );

    fpwc_core #(
        .PAGE_BYTES   (PAGE_BYTES),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .stg_valid (stg_valid),
        .stg_item  (stg_item),
        .free      (free),
        .consume   (consume),
        .push      (push)
    );

    fpwc_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .free      (free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    assign command         = result.command;
    assign command_address = result.command_address;
    assign word_data       = result.word_data;
    assign last            = result.last;

endmodule

// ----- design/fpwc_in_stage.sv -----
module fpwc_in_stage
    import fpwc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    input  logic  consume,
    output logic  stg_valid,
    output item_t stg_item
);

    logic  stg_valid_reg;
    logic  stg_valid_next;
    item_t stg_item_reg;

    assign in_ready       = !stg_valid_reg || consume;
    assign stg_valid_next = (in_valid && in_ready) || (stg_valid_reg && !consume);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stg_item_reg <= in_item;
        end
    end

    assign stg_valid = stg_valid_reg;
    assign stg_item  = stg_item_reg;

endmodule

// ----- design/fpwc_core.sv -----
module fpwc_core
    import fpwc_pkg::*;
#(
    parameter int PAGE_BYTES   = 512,
    parameter int ADDRESS_BITS = 17
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              stg_valid,
    input  item_t             stg_item,
    input  logic [QCNT_W-1:0] free,
    output logic              consume,
    output push_t             push
);

    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int ADDR_KEEP  = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
    localparam logic [ADDR_W-1:0] IN_MASK    = ADDR_W'((64'd1 << ADDR_KEEP) - 64'd1);
    localparam logic [31:0]       START_MASK = 32'((64'd1 << ADDRESS_BITS) - 64'd1);
    localparam logic [ADDR_W-1:0] OFFS_MASK  = ADDR_W'(PAGE_BYTES - 1);

    function automatic logic [ADDR_W-1:0] page_start(input logic [7:0] pg);
        logic [31:0] full;
        full = (32'(pg) << PAGE_SHIFT) & START_MASK;
        return full[ADDR_W-1:0];
    endfunction

    logic [7:0] held_page_reg;
    logic [7:0] held_page_next;
    logic       dirty_reg;
    logic       dirty_next;
    logic [7:0] latch_reg;
    logic [7:0] latch_next;

    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] offs;
    logic [7:0]        page;
    logic              odd;
    logic              change;
    logic [1:0]        count;
    result_t           ew_res;
    result_t           load_res;
    result_t           erase_res;
    result_t           first;
    result_t           second;

    assign addr   = stg_item.byte_address & IN_MASK;
    assign page   = 8'(addr >> PAGE_SHIFT);
    assign offs   = addr & OFFS_MASK;
    assign odd    = offs[0];
    assign change = (page != held_page_reg) && dirty_reg;

    always_comb
    begin
        ew_res.command          = CMD_ERASE_WRITE;
        ew_res.command_address  = page_start(held_page_reg);
        ew_res.word_data        = 16'd0;
        ew_res.last             = 1'b1;

        load_res.command         = CMD_LOAD;
        load_res.command_address = offs;
        load_res.word_data       = {stg_item.data_byte, latch_reg};
        load_res.last            = 1'b1;

        erase_res.command         = CMD_ERASE;
        erase_res.command_address = page_start(stg_item.page_number);
        erase_res.word_data       = 16'd0;
        erase_res.last            = 1'b1;

        first          = load_res;
        second         = load_res;
        count          = 2'd0;
        held_page_next = held_page_reg;
        dirty_next     = dirty_reg;
        latch_next     = latch_reg;

        case (stg_item.func)
            FUNC_WRITE:
            begin
                if (change)
                begin
                    first      = ew_res;
                    first.last = !odd;
                    count      = odd ? 2'd2 : 2'd1;
                end
                else if (odd)
                begin
                    count = 2'd1;
                end
                held_page_next = page;
                dirty_next     = 1'b1;
                if (!odd)
                begin
                    latch_next = stg_item.data_byte;
                end
            end
            FUNC_FLUSH:
            begin
                if (dirty_reg)
                begin
                    first      = ew_res;
                    count      = 2'd1;
                    dirty_next = 1'b0;
                end
            end
            FUNC_ERASE:
            begin
                first = erase_res;
                count = 2'd1;
            end
            default:
            begin
                count = 2'd0;
            end
        endcase
    end

    assign consume     = stg_valid && (QCNT_W'(count) <= free);
    assign push.count  = consume ? count : 2'd0;
    assign push.first  = first;
    assign push.second = second;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_page_reg <= 8'd0;
            dirty_reg     <= 1'b0;
            latch_reg     <= 8'd0;
        end
        else if (consume)
        begin
            held_page_reg <= held_page_next;
            dirty_reg     <= dirty_next;
            latch_reg     <= latch_next;
        end
    end

endmodule

// ----- design/fpwc_out_queue.sv -----
module fpwc_out_queue
    import fpwc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  push_t             push,
    output logic [QCNT_W-1:0] free,
    output logic              out_valid,
    input  logic              out_ready,
    output result_t           result
);

    result_t             entries_reg [QUEUE_DEPTH];
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic                pop;

    assign out_valid   = (count_reg != '0);
    assign pop         = out_valid && out_ready;
    assign free        = QCNT_W'(QUEUE_DEPTH) - count_reg;
    assign count_next  = count_reg + QCNT_W'(push.count) - QCNT_W'(pop);
    assign wr_ptr_next = wr_ptr_reg + QPTR_W'(push.count);
    assign rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
    assign result      = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entries_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entries_reg[wr_ptr_reg + QPTR_W'(1)] <= push.second;
        end
    end

endmodule

// ----- design/fpwc_checker.sv -----
`include "assert_macros.svh"

module fpwc_checker
    import fpwc_pkg::*;
#(
    parameter int PAGE_BYTES = 512
)
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [1:0]        command,
    input logic [ADDR_W-1:0] command_address,
    input logic [15:0]       word_data,
    input logic              last
);

    localparam logic [ADDR_W:0] PAGE_LIMIT = (ADDR_W + 1)'(PAGE_BYTES);

    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                 out_valid && $stable(command) && $stable(command_address)
                     && $stable(word_data) && $stable(last),
                 "stalled result changed")
    `ASSERT_SAME(a_cmd_code, out_valid,
                 (command == CMD_LOAD) || (((command == CMD_ERASE_WRITE)
                     || (command == CMD_ERASE)) && (word_data == 16'd0)),
                 "bad command or nonzero word")
    `ASSERT_SAME(a_load_offs, out_valid && (command == CMD_LOAD),
                 {1'b0, command_address} < PAGE_LIMIT, "load offset beyond page")
    `ASSERT_SAME(a_stall_cause, !in_ready, out_valid, "input stalled with no result pending")

endmodule

bind flash_page_write_combiner fpwc_checker #(.PAGE_BYTES(PAGE_BYTES)) u_fpwc_checker (.*);

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import fpwc_pkg::*;

    localparam int PAGE_BYTES   = 512;
    localparam int ADDRESS_BITS = 17;
    localparam int ITEM_COUNT   = 2000;
    localparam int TAIL_CYCLES  = 12;
    localparam int ADDR_LIMIT   = (1 << ADDR_W) - 1;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    class write_combiner_scoreboard;
        logic [7:0] held_page;
        logic       dirty;
        logic [7:0] low_latch;
        result_t    pending_commands[$];
        int         errors;

        function new();
            held_page = '0;
            dirty     = 1'b0;
            low_latch = '0;
            errors    = 0;
        endfunction

        function int page_start(logic [7:0] pg);
            return (int'(pg) * PAGE_BYTES) & ((1 << ADDRESS_BITS) - 1);
        endfunction

        function result_t form_command(logic [1:0] cmd, int addr, logic [15:0] word);
            result_t r;
            r.command         = cmd;
            r.command_address = ADDR_W'(addr);
            r.word_data       = word;
            r.last            = 1'b0;
            return r;
        endfunction

        function void take_item(item_t it);
            result_t    cmds[$];
            int         addr;
            int         offs;
            logic [7:0] pg;
            addr = int'(it.byte_address) & ((1 << ADDRESS_BITS) - 1);
            case (it.func)
                FUNC_WRITE:
                begin
                    pg   = 8'(addr / PAGE_BYTES);
                    offs = addr % PAGE_BYTES;
                    if (pg != held_page && dirty)
                        cmds.push_back(form_command(CMD_ERASE_WRITE, page_start(held_page), '0));
                    held_page = pg;
                    if (offs % 2 == 0)
                        low_latch = it.data_byte;
                    else
                        cmds.push_back(form_command(CMD_LOAD, offs, {it.data_byte, low_latch}));
                    dirty = 1'b1;
                end
                FUNC_FLUSH:
                begin
                    if (dirty)
                    begin
                        cmds.push_back(form_command(CMD_ERASE_WRITE, page_start(held_page), '0));
                        dirty = 1'b0;
                    end
                end
                FUNC_ERASE:
                    cmds.push_back(form_command(CMD_ERASE, page_start(it.page_number), '0));
                default:
                    ;
            endcase
            if (cmds.size() > 0)
                cmds[cmds.size() - 1].last = 1'b1;
            foreach (cmds[i])
                pending_commands.push_back(cmds[i]);
        endfunction

        function void check_command(result_t got);
            result_t want;
            if (pending_commands.size() == 0)
            begin
                $error("command %0d at %0h with nothing expected", got.command,
                       got.command_address);
                errors++;
                return;
            end
            want = pending_commands.pop_front();
            if (got.command !== want.command)
            begin
                $error("command: expected %0d, got %0d", want.command, got.command);
                errors++;
            end
            if (got.command_address !== want.command_address)
            begin
                $error("command_address: expected %0h, got %0h", want.command_address,
                       got.command_address);
                errors++;
            end
            if (got.word_data !== want.word_data)
            begin
                $error("word_data: expected %0h, got %0h", want.word_data, got.word_data);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [1:0]        func;
    logic [ADDR_W-1:0] byte_address;
    logic [7:0]        data_byte;
    logic [7:0]        page_number;
    logic              out_valid;
    logic              out_ready;
    logic [1:0]        command;
    logic [ADDR_W-1:0] command_address;
    logic [15:0]       word_data;
    logic              last;

    write_combiner_scoreboard sb = new();
    int items_sent = 0;
    bit steady_feed = 1'b0;

    flash_page_write_combiner #(
        .PAGE_BYTES   (PAGE_BYTES),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .byte_address    (byte_address),
        .data_byte       (data_byte),
        .page_number     (page_number),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .command         (command),
        .command_address (command_address),
        .word_data       (word_data),
        .last            (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #10ms;
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        item_t   seen_item;
        result_t seen_command;
        if (rst_n === 1'b1 && in_valid && in_ready)
        begin
            seen_item.func         = func;
            seen_item.byte_address = byte_address;
            seen_item.data_byte    = data_byte;
            seen_item.page_number  = page_number;
            sb.take_item(seen_item);
        end
        if (rst_n === 1'b1 && out_valid && out_ready)
        begin
            seen_command.command         = command;
            seen_command.command_address = command_address;
            seen_command.word_data       = word_data;
            seen_command.last            = last;
            sb.check_command(seen_command);
        end
    end

    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic item_t write_byte(int addr, int data);
        item_t it;
        it.func         = FUNC_WRITE;
        it.byte_address = ADDR_W'(addr);
        it.data_byte    = 8'(data);
        it.page_number  = 8'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic item_t control_item(logic [1:0] f, int pg);
        item_t it;
        it.func         = f;
        it.byte_address = ADDR_W'($urandom_range(0, ADDR_LIMIT));
        it.data_byte    = 8'($urandom_range(0, 255));
        it.page_number  = 8'(pg);
        return it;
    endfunction

    function automatic int pick_page();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return $urandom_range(0, 2);
        if (r < 55)
            return 255;
        return $urandom_range(0, 255);
    endfunction

    task automatic send_item(input item_t it);
        int gap;
        gap = steady_feed ? 0 : idle_cycles();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        func         <= it.func;
        byte_address <= it.byte_address;
        data_byte    <= it.data_byte;
        page_number  <= it.page_number;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (it.func != FUNC_UNUSED)
            items_sent++;
    endtask

    task automatic run_directed();
        send_item(control_item(FUNC_FLUSH, 0));
        send_item(control_item(FUNC_UNUSED, 255));
        send_item(write_byte(1, 8'hAB));
        send_item(write_byte(2, 8'h34));
        send_item(write_byte(3, 8'h12));
        send_item(write_byte(ADDR_LIMIT, 8'hFF));
        send_item(control_item(FUNC_FLUSH, 3));
        send_item(control_item(FUNC_FLUSH, 3));
        send_item(control_item(FUNC_ERASE, 0));
        send_item(control_item(FUNC_ERASE, 255));
        send_item(write_byte(ADDR_LIMIT - 1, 8'h00));
        send_item(control_item(FUNC_ERASE, 7));
        send_item(control_item(FUNC_UNUSED, 0));
        send_item(write_byte(0, 8'hFF));
        send_item(write_byte(PAGE_BYTES - 1, 8'hFF));
        send_item(write_byte(PAGE_BYTES, 8'h00));
        send_item(write_byte(PAGE_BYTES + 1, 8'h00));
        send_item(write_byte(2 * PAGE_BYTES + 5, 8'h80));
        send_item(control_item(FUNC_FLUSH, 0));
        send_item(write_byte(ADDR_LIMIT - PAGE_BYTES + 2, 8'h55));
        send_item(write_byte(ADDR_LIMIT - PAGE_BYTES + 3, 8'hAA));
        send_item(control_item(FUNC_FLUSH, 0));
    endtask

    task automatic run_random_burst();
        int r;
        int pg;
        int offs;
        int words;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            pg    = pick_page();
            offs  = 2 * $urandom_range(0, PAGE_BYTES / 2 - 1);
            words = $urandom_range(1, 8);
            repeat (words)
            begin
                send_item(write_byte(pg * PAGE_BYTES + offs, $urandom_range(0, 255)));
                send_item(write_byte(pg * PAGE_BYTES + offs + 1, $urandom_range(0, 255)));
                offs = (offs + 2) % PAGE_BYTES;
            end
        end
        else if (r < 70)
            send_item(write_byte($urandom_range(0, ADDR_LIMIT), $urandom_range(0, 255)));
        else if (r < 80)
            send_item(control_item(FUNC_FLUSH, $urandom_range(0, 255)));
        else if (r < 88)
            send_item(control_item(FUNC_ERASE, $urandom_range(0, 255)));
        else if (r < 93)
            send_item(control_item(FUNC_UNUSED, $urandom_range(0, 255)));
        else
        begin
            pg   = pick_page();
            offs = $urandom_range(0, PAGE_BYTES - 1);
            send_item(write_byte(pg * PAGE_BYTES + (offs | 1), $urandom_range(0, 255)));
            send_item(write_byte(pick_page() * PAGE_BYTES + (offs & ~1),
                                 $urandom_range(0, 255)));
        end
    endtask

    initial
    begin : receiver
        int burst;
        int hold;
        int cycles;
        bit long_hold_done;
        cycles         = 0;
        long_hold_done = 1'b0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                : $urandom_range(1, 8);
            hold  = idle_cycles();
            out_ready <= 1'b1;
            repeat (burst) @(posedge clk);
            cycles += burst;
            if (!long_hold_done && cycles > 1000)
            begin
                hold           = 400;
                long_hold_done = 1'b1;
            end
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
                cycles += hold;
            end
        end
    end

    initial
    begin
        in_valid     <= 1'b0;
        func         <= FUNC_WRITE;
        byte_address <= '0;
        data_byte    <= '0;
        page_number  <= '0;
        rst_n        <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        while (items_sent < ITEM_COUNT)
        begin
            steady_feed = ($urandom_range(0, 5) == 0);
            run_random_burst();
        end
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_commands.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
